// ----- rtl/core/sample_set_statistics_defines.svh -----
// ----------------------------------------------------------------------------
// sample_set_statistics_defines.svh
// Assertion macros shared by the sample set statistics RTL.
// ----------------------------------------------------------------------------
`ifndef SAMPLE_SET_STATISTICS_DEFINES_SVH
`define SAMPLE_SET_STATISTICS_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SSS_ASSERT_HOLDS(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define SSS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/sss_pkg.sv -----
// ----------------------------------------------------------------------------
// sss_pkg
// Shared types and fixed result widths for the sample set statistics block.
// ----------------------------------------------------------------------------
package sss_pkg;

    localparam int COUNT_W     = 9;
    localparam int TOTAL_W     = 24;
    localparam int PRODUCT_W   = 64;
    localparam int MEAN_W      = 24;
    localparam int MEDIAN_W    = 17;
    localparam int MEAN_FRAC_W = 8;
    localparam int WIDE_W      = 64;

    localparam logic [PRODUCT_W-1:0] PROD_MAX = {1'b0, {(PRODUCT_W-1){1'b1}}};
    localparam logic [PRODUCT_W-1:0] PROD_MIN = {1'b1, {(PRODUCT_W-1){1'b0}}};
    localparam logic [PRODUCT_W-1:0] PROD_ONE = {{(PRODUCT_W-1){1'b0}}, 1'b1};

    typedef struct packed {
        logic insert;
        logic drain;
    } chain_ctl_t;

endpackage

// ----- rtl/core/sss_cell.sv -----
// ----------------------------------------------------------------------------
// sss_cell
// One slot of the insertion chain: holds one sorted sample.
// ----------------------------------------------------------------------------
module sss_cell #(
    parameter int W     = 16,
    parameter int CNT_W = 9,
    parameter int IDX   = 0
) (
    input  logic                    clk,
    input  sss_pkg::chain_ctl_t     ctl,
    input  logic [CNT_W-1:0]        fill,
    input  logic signed [W-1:0]     sample,
    input  logic signed [W-1:0]     left_val,
    input  logic                    left_gt,
    input  logic signed [W-1:0]     right_val,
    output logic signed [W-1:0]     val,
    output logic                    gt
);

    logic signed [W-1:0] val_reg;
    logic                occ;
    logic                tail;

    assign occ  = fill > CNT_W'(IDX);
    assign tail = fill == CNT_W'(IDX);
    assign gt   = occ && (val_reg > sample);
    assign val  = val_reg;

    // insert: shift right above the insertion point; drain: shift left
    always_ff @(posedge clk)
    begin
        if (ctl.drain)
        begin
            val_reg <= right_val;
        end
        else if (ctl.insert)
        begin
            if (left_gt)
            begin
                val_reg <= left_val;
            end
            else if (gt || tail)
            begin
                val_reg <= sample;
            end
        end
    end

endmodule

// ----- rtl/core/sss_divider.sv -----
// ----------------------------------------------------------------------------
// sss_divider
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sss_divider #(
    parameter int DVD_W = 33,
    parameter int DVS_W = 9
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    localparam int STEP_W = $clog2(DVD_W + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [DVS_W-1:0]  rem_reg;
    logic [DVS_W-1:0]  dvs_reg;
    logic [DVD_W-1:0]  quo_reg;

    logic [DVS_W:0]    trial;
    logic [DVS_W:0]    diff;
    logic              ge;
    logic [DVS_W-1:0]  rem_next;
    logic [DVD_W-1:0]  quo_next;

    assign trial    = {rem_reg, quo_reg[DVD_W-1]};
    assign ge       = trial >= {1'b0, dvs_reg};
    assign diff     = trial - {1'b0, dvs_reg};
    assign rem_next = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
    assign quo_next = {quo_reg[DVD_W-2:0], ge};

    assign done     = done_reg;
    assign quotient = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= STEP_W'(DVD_W);
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg - 1'b1;
            if (step_reg == STEP_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dvs_reg <= divisor;
            quo_reg <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

endmodule

// ----- rtl/core/sample_set_statistics.sv -----
// ----------------------------------------------------------------------------
// sample_set_statistics
// Sorts a set of samples in an insertion chain, accumulates sum and
// saturating product, and reports count, sum, product, mean and median.
// ----------------------------------------------------------------------------
//  channel  | handshake           | payload
//  ---------+---------------------+---------------------------------------------
//  in       | in_valid / in_ready | sample, last
//  out      | out_valid/out_ready | count, total, product, product_overflow,
//           |                     | mean_q8, median_x2, too_many
//
// One sample request per cycle while a set is open.
// After the last request the chain shifts out to the median while the mean
// divider runs; the result registers once both are done, and input is held
// off until then.
// The result sits in an output register; the next set is taken meanwhile and
// holds at its finish until that register is free.
// Reset empties the set; chain contents are not cleared.
// ----------------------------------------------------------------------------
`include "sample_set_statistics_defines.svh"

module sample_set_statistics #(
    parameter int MAX_SAMPLES = 256,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [SAMPLE_BITS-1:0]                sample,
    input  logic                                  last,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [sss_pkg::COUNT_W-1:0]           count,
    output logic signed [sss_pkg::TOTAL_W-1:0]    total,
    output logic signed [sss_pkg::PRODUCT_W-1:0]  product,
    output logic                                  product_overflow,
    output logic signed [sss_pkg::MEAN_W-1:0]     mean_q8,
    output logic signed [sss_pkg::MEDIAN_W-1:0]   median_x2,
    output logic                                  too_many
);

    import sss_pkg::*;

    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W = SAMPLE_BITS + CNT_W;
    localparam int DVD_W = SUM_W + MEAN_FRAC_W;
    localparam int PRD_W = PRODUCT_W + SAMPLE_BITS;
    localparam int MED_W = SAMPLE_BITS + 1;

    typedef enum logic {ST_COLLECT, ST_FINISH} state_t;

    state_t                         state_reg;
    logic [CNT_W-1:0]               cnt_reg;
    logic [CNT_W-1:0]               drain_k_reg;
    logic signed [SUM_W-1:0]        sum_reg;
    logic signed [PRODUCT_W-1:0]    prod_reg;
    logic                           prod_sat_reg;
    logic                           drop_reg;
    logic                           med_done_reg;
    logic                           div_start_reg;
    logic                           out_valid_reg;
    logic signed [SAMPLE_BITS-1:0]  med_lo_reg;
    logic signed [SAMPLE_BITS-1:0]  med_hi_reg;

    logic [COUNT_W-1:0]             count_reg;
    logic [TOTAL_W-1:0]             total_reg;
    logic [PRODUCT_W-1:0]           product_reg;
    logic                           product_overflow_reg;
    logic [MEAN_W-1:0]              mean_q8_reg;
    logic [MEDIAN_W-1:0]            median_x2_reg;
    logic                           too_many_reg;

    logic                           accept;
    logic                           room;
    logic                           keep;
    logic                           finish_ok;
    logic [CNT_W-1:0]               mid;
    logic signed [SAMPLE_BITS-1:0]  sample_s;
    logic signed [SUM_W-1:0]        sample_ext;
    logic signed [PRD_W-1:0]        prod_full;
    logic [PRD_W-PRODUCT_W:0]       prod_hi;
    logic                           prod_ovf;
    logic [PRODUCT_W-1:0]           prod_step;
    logic                           sum_neg;
    logic [SUM_W-1:0]               sum_mag;
    logic [DVD_W-1:0]               dividend;
    logic [DVD_W-1:0]               div_q;
    logic                           div_done;
    logic [DVD_W:0]                 mean_s;
    logic signed [MED_W-1:0]        med_a;
    logic signed [MED_W-1:0]        med_b;
    logic signed [MED_W-1:0]        med2;
    logic [WIDE_W-1:0]              count_wide;
    logic [WIDE_W-1:0]              total_wide;
    logic [WIDE_W-1:0]              mean_wide;
    logic [WIDE_W-1:0]              med_wide;
    chain_ctl_t                     ctl;

    logic signed [SAMPLE_BITS-1:0]  chain_val [MAX_SAMPLES];
    logic                           chain_gt  [MAX_SAMPLES];

    assign in_ready   = state_reg == ST_COLLECT;
    assign accept     = in_valid && in_ready;
    assign room       = cnt_reg < CNT_W'(MAX_SAMPLES);
    assign keep       = accept && room;
    assign mid        = cnt_reg >> 1;
    assign sample_s   = $signed(sample);
    assign sample_ext = {{CNT_W{sample[SAMPLE_BITS-1]}}, sample};

    // saturating product: exact 64 x SAMPLE_BITS product, clamp if it leaves 64 bits
    assign prod_full = prod_reg * sample_s;
    assign prod_hi   = prod_full[PRD_W-1:PRODUCT_W-1];
    assign prod_ovf  = !((&prod_hi) || !(|prod_hi));
    assign prod_step = prod_ovf ? (prod_full[PRD_W-1] ? PROD_MIN : PROD_MAX)
                                : prod_full[PRODUCT_W-1:0];

    assign finish_ok = (state_reg == ST_FINISH) && med_done_reg && div_done
                       && (!out_valid_reg || out_ready);

    assign ctl.insert = keep;
    assign ctl.drain  = (state_reg == ST_FINISH) && !med_done_reg;

    // mean: |sum| * 256 / count, sign restored afterward
    assign sum_neg  = sum_reg[SUM_W-1];
    assign sum_mag  = sum_neg ? (~sum_reg + 1'b1) : sum_reg;
    assign dividend = {sum_mag, {MEAN_FRAC_W{1'b0}}};
    assign mean_s   = sum_neg ? (~{1'b0, div_q} + 1'b1) : {1'b0, div_q};

    assign med_a = {med_hi_reg[SAMPLE_BITS-1], med_hi_reg};
    assign med_b = cnt_reg[0] ? {med_hi_reg[SAMPLE_BITS-1], med_hi_reg}
                              : {med_lo_reg[SAMPLE_BITS-1], med_lo_reg};
    assign med2  = med_a + med_b;

    assign count_wide = {{(WIDE_W-CNT_W){1'b0}}, cnt_reg};
    assign total_wide = {{(WIDE_W-SUM_W){sum_reg[SUM_W-1]}}, sum_reg};
    assign mean_wide  = {{(WIDE_W-DVD_W-1){mean_s[DVD_W]}}, mean_s};
    assign med_wide   = {{(WIDE_W-MED_W){med2[MED_W-1]}}, med2};

    genvar gi;
    generate
        for (gi = 0; gi < MAX_SAMPLES; gi++)
        begin : g_chain
            logic signed [SAMPLE_BITS-1:0] left_v;
            logic                          left_g;
            logic signed [SAMPLE_BITS-1:0] right_v;

            if (gi == 0)
            begin : g_head
                assign left_v = sample_s;
                assign left_g = 1'b0;
            end
            else
            begin : g_body
                assign left_v = chain_val[gi-1];
                assign left_g = chain_gt[gi-1];
            end

            if (gi == MAX_SAMPLES - 1)
            begin : g_tail
                assign right_v = chain_val[gi];
            end
            else
            begin : g_inner
                assign right_v = chain_val[gi+1];
            end

            sss_cell #(
                .W     (SAMPLE_BITS),
                .CNT_W (CNT_W),
                .IDX   (gi)
            ) u_cell (
                .clk       (clk),
                .ctl       (ctl),
                .fill      (cnt_reg),
                .sample    (sample_s),
                .left_val  (left_v),
                .left_gt   (left_g),
                .right_val (right_v),
                .val       (chain_val[gi]),
                .gt        (chain_gt[gi])
            );
        end
    endgenerate

    sss_divider #(
        .DVD_W (DVD_W),
        .DVS_W (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start_reg),
        .dividend (dividend),
        .divisor  (cnt_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_COLLECT;
            cnt_reg       <= '0;
            drain_k_reg   <= '0;
            sum_reg       <= '0;
            prod_reg      <= PROD_ONE;
            prod_sat_reg  <= 1'b0;
            drop_reg      <= 1'b0;
            med_done_reg  <= 1'b0;
            div_start_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            div_start_reg <= 1'b0;

            if (keep)
            begin
                cnt_reg  <= cnt_reg + 1'b1;
                sum_reg  <= sum_reg + sample_ext;
                prod_reg <= prod_step;
                if (prod_ovf)
                begin
                    prod_sat_reg <= 1'b1;
                end
            end

            if (accept && !room)
            begin
                drop_reg <= 1'b1;
            end

            if (accept && last)
            begin
                state_reg     <= ST_FINISH;
                drain_k_reg   <= '0;
                med_done_reg  <= 1'b0;
                div_start_reg <= 1'b1;
            end

            if ((state_reg == ST_FINISH) && !med_done_reg)
            begin
                drain_k_reg <= drain_k_reg + 1'b1;
                if (drain_k_reg == mid)
                begin
                    med_done_reg <= 1'b1;
                end
            end

            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (finish_ok)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= ST_COLLECT;
                cnt_reg       <= '0;
                sum_reg       <= '0;
                prod_reg      <= PROD_ONE;
                prod_sat_reg  <= 1'b0;
                drop_reg      <= 1'b0;
            end
        end
    end

    // cell 0 shows sorted[k] during the drain
    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_FINISH) && !med_done_reg)
        begin
            if (CNT_W'(drain_k_reg + 1'b1) == mid)
            begin
                med_lo_reg <= chain_val[0];
            end
            if (drain_k_reg == mid)
            begin
                med_hi_reg <= chain_val[0];
            end
        end

        if (finish_ok)
        begin
            count_reg            <= count_wide[COUNT_W-1:0];
            total_reg            <= total_wide[TOTAL_W-1:0];
            product_reg          <= prod_reg;
            product_overflow_reg <= prod_sat_reg;
            mean_q8_reg          <= mean_wide[MEAN_W-1:0];
            median_x2_reg        <= med_wide[MEDIAN_W-1:0];
            too_many_reg         <= drop_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign count            = count_reg;
    assign total            = total_reg;
    assign product          = product_reg;
    assign product_overflow = product_overflow_reg;
    assign mean_q8          = mean_q8_reg;
    assign median_x2        = median_x2_reg;
    assign too_many         = too_many_reg;

    `SSS_ASSERT_HOLDS(a_fill_in_range, 1'b1, cnt_reg <= CNT_W'(MAX_SAMPLES), "fill count beyond capacity")
    `SSS_ASSERT_HOLDS(a_chain_sorted, (state_reg == ST_COLLECT) && (cnt_reg >= CNT_W'(2)), chain_val[0] <= chain_val[1], "chain head out of order")
    `SSS_ASSERT_HOLDS(a_div_nonzero, div_start_reg, (state_reg == ST_FINISH) && (cnt_reg != '0), "divider started with empty set")
    `SSS_ASSERT_NEXT(a_set_cleared, finish_ok, (cnt_reg == '0) && (sum_reg == '0) && (prod_reg == PROD_ONE), "set not cleared after result")

endmodule

// ----- sim/sample_set_statistics_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sample_set_statistics_tb
// Streams sample sets into the statistics block under random sender bursts
// and receiver stalls, predicts count, sum, saturating product, Q8 mean and
// doubled median per set, and compares each result as it leaves the block.
// ----------------------------------------------------------------------------
module sample_set_statistics_tb;

    localparam int SAMPLE_BITS    = 16;
    localparam int CAPACITY       = 256;
    localparam int CLK_PERIOD     = 12;
    localparam int RANDOM_ITEMS   = 400;
    localparam int LONG_HOLD      = 400;
    localparam int DRAIN_CYCLES   = 60;
    localparam int TIMEOUT_CYCLES = 400000;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    typedef struct {
        logic        [sss_pkg::COUNT_W-1:0]   count;
        logic signed [sss_pkg::TOTAL_W-1:0]   total;
        logic signed [sss_pkg::PRODUCT_W-1:0] product;
        logic                                 product_overflow;
        logic signed [sss_pkg::MEAN_W-1:0]    mean_q8;
        logic signed [sss_pkg::MEDIAN_W-1:0]  median_x2;
        logic                                 too_many;
    } set_stats_t;

    class set_stats_scoreboard;
        sample_t                         ordered [CAPACITY];
        int                              kept;
        longint                          sum_acc;
        logic signed [sss_pkg::PRODUCT_W-1:0] prod_acc;
        bit                              prod_sat;
        bit                              drop_seen;
        set_stats_t                      expected_q [$];
        int                              errors;
        int                              samples_seen;
        int                              results_checked;
        int                              saturated_sets;
        int                              dropped_sets;

        function new();
            errors          = 0;
            samples_seen    = 0;
            results_checked = 0;
            saturated_sets  = 0;
            dropped_sets    = 0;
            clear_set();
        endfunction

        function void clear_set();
            kept      = 0;
            sum_acc   = 0;
            prod_acc  = sss_pkg::PROD_ONE;
            prod_sat  = 1'b0;
            drop_seen = 1'b0;
        endfunction

        function int pending_count();
            return expected_q.size();
        endfunction

        function void note_sample(sample_t s, bit is_last);
            int                 i;
            logic signed [127:0] wide;
            longint             mean;
            int                 med;
            set_stats_t         e;
            samples_seen++;
            if (kept < CAPACITY)
            begin
                i = kept;
                while (i > 0 && ordered[i-1] > s)
                begin
                    ordered[i] = ordered[i-1];
                    i--;
                end
                ordered[i] = s;
                kept++;
                sum_acc += s;
                wide = prod_acc * s;
                if (wide > $signed(sss_pkg::PROD_MAX))
                begin
                    prod_acc = sss_pkg::PROD_MAX;
                    prod_sat = 1'b1;
                end
                else if (wide < $signed(sss_pkg::PROD_MIN))
                begin
                    prod_acc = sss_pkg::PROD_MIN;
                    prod_sat = 1'b1;
                end
                else
                begin
                    prod_acc = wide[63:0];
                end
            end
            else
            begin
                drop_seen = 1'b1;
            end
            if (is_last)
            begin
                if (kept % 2 == 1)
                    med = 2 * int'(ordered[kept/2]);
                else
                    med = int'(ordered[kept/2-1]) + int'(ordered[kept/2]);
                mean = (sum_acc * 256) / kept;
                e.count            = kept[sss_pkg::COUNT_W-1:0];
                e.total            = sum_acc[sss_pkg::TOTAL_W-1:0];
                e.product          = prod_acc;
                e.product_overflow = prod_sat;
                e.mean_q8          = mean[sss_pkg::MEAN_W-1:0];
                e.median_x2        = med[sss_pkg::MEDIAN_W-1:0];
                e.too_many         = drop_seen;
                if (prod_sat)
                    saturated_sets++;
                if (drop_seen)
                    dropped_sets++;
                expected_q.push_back(e);
                clear_set();
            end
        endfunction

        function void compare_field(string name, longint exp_v, longint act_v);
            if (exp_v != act_v)
            begin
                $display("%0t: %s mismatch, expected %0d actual %0d", $time, name,
                         exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_result(set_stats_t got);
            set_stats_t e;
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result, expected none actual count %0d",
                         $time, got.count);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            results_checked++;
            compare_field("count", e.count, got.count);
            compare_field("total", e.total, got.total);
            compare_field("product", e.product, got.product);
            compare_field("product_overflow", e.product_overflow, got.product_overflow);
            compare_field("mean_q8", e.mean_q8, got.mean_q8);
            compare_field("median_x2", e.median_x2, got.median_x2);
            compare_field("too_many", e.too_many, got.too_many);
        endfunction
    endclass

    logic                                 clk;
    logic                                 rst_n     = 1'b0;
    logic                                 in_valid  = 1'b0;
    logic                                 in_ready;
    logic [SAMPLE_BITS-1:0]               sample    = '0;
    logic                                 last      = 1'b0;
    logic                                 out_valid;
    logic                                 out_ready = 1'b0;
    logic [sss_pkg::COUNT_W-1:0]          count;
    logic signed [sss_pkg::TOTAL_W-1:0]   total;
    logic signed [sss_pkg::PRODUCT_W-1:0] product;
    logic                                 product_overflow;
    logic signed [sss_pkg::MEAN_W-1:0]    mean_q8;
    logic signed [sss_pkg::MEDIAN_W-1:0]  median_x2;
    logic                                 too_many;

    set_stats_scoreboard sb = new();

    sample_t set_buf [$];
    int      burst_left   = 0;
    bit      hold_request = 1'b0;
    bit      hold_done    = 1'b0;

    sample_set_statistics #(
        .MAX_SAMPLES (CAPACITY),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .sample           (sample),
        .last             (last),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .count            (count),
        .total            (total),
        .product          (product),
        .product_overflow (product_overflow),
        .mean_q8          (mean_q8),
        .median_x2        (median_x2),
        .too_many         (too_many)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD/2) clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("%0t: timeout, %0d results still pending", $time, sb.pending_count());
        $display("sample_set_statistics_tb: errors");
        $finish;
    end

    always @(posedge clk)
    begin
        set_stats_t got;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_sample($signed(sample), last);
            if (out_valid && out_ready)
            begin
                got.count            = count;
                got.total            = total;
                got.product          = product;
                got.product_overflow = product_overflow;
                got.mean_q8          = mean_q8;
                got.median_x2        = median_x2;
                got.too_many         = too_many;
                sb.check_result(got);
            end
        end
    end

    // receiver: random ready phases, one long hold-off on request
    initial
    begin
        int mode;
        int len;
        wait (rst_n);
        forever
        begin
            if (hold_request && !hold_done)
            begin
                hold_done = 1'b1;
                repeat (LONG_HOLD)
                begin
                    @(posedge clk);
                    out_ready <= 1'b0;
                end
            end
            else
            begin
                mode = $urandom_range(0, 3);
                len  = $urandom_range(1, 40);
                repeat (len)
                begin
                    @(posedge clk);
                    case (mode)
                        0: out_ready <= 1'b1;
                        1: out_ready <= 1'b0;
                        2: out_ready <= $urandom_range(0, 1);
                        default: out_ready <= ($urandom_range(0, 3) != 0);
                    endcase
                end
            end
        end
    end

    task automatic send_item(sample_t s, bit is_last);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        in_valid <= 1'b1;
        sample   <= s;
        last     <= is_last;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic send_set();
        foreach (set_buf[i])
            send_item(set_buf[i], i == set_buf.size() - 1);
    endtask

    function automatic sample_t pick_sample(int mode);
        sample_t s;
        case (mode)
            0: s = sample_t'($urandom());
            1: s = sample_t'($urandom_range(0, 6) - 3);
            2:
            begin
                case ($urandom_range(0, 4))
                    0: s = sample_t'(-32768);
                    1: s = sample_t'(32767);
                    2: s = sample_t'(0);
                    3: s = sample_t'(-1);
                    default: s = sample_t'(1);
                endcase
            end
            default: s = ($urandom_range(0, 1) != 0) ? sample_t'($urandom())
                                                     : sample_t'($urandom_range(0, 40) - 20);
        endcase
        return s;
    endfunction

    initial
    begin
        int random_items;
        int len;
        int mode;
        bit big_done;
        random_items = 0;
        big_done     = 1'b0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_buf = '{32767};
        send_set();
        set_buf = '{-32768};
        send_set();
        set_buf = '{0, -1};
        send_set();
        set_buf = '{3, 2, 1, 0};
        send_set();
        set_buf = '{1, -2, 0};
        send_set();
        // negative saturation, then negated bound, then zero
        set_buf = '{-32768, -32768, -32768, -32768, -32768, -1, 0};
        send_set();
        // exact minimum, then saturates positive
        set_buf = '{-32768, -32768, -32768, -32768, -8, -1};
        send_set();

        while (random_items < RANDOM_ITEMS)
        begin
            if (!big_done && random_items >= 120)
            begin
                len      = CAPACITY + 3;
                big_done = 1'b1;
            end
            else if ($urandom_range(0, 5) == 0)
                len = $urandom_range(13, 40);
            else
                len = $urandom_range(1, 12);
            if (random_items >= 60)
                hold_request = 1'b1;
            mode = $urandom_range(0, 3);
            set_buf = {};
            repeat (len)
                set_buf.push_back(pick_sample(mode));
            send_set();
            random_items += len;
        end
        in_valid <= 1'b0;
        last     <= 1'b0;

        while (sb.pending_count() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d samples, %0d sets checked", sb.samples_seen,
                 sb.results_checked);
        $display("%0d sets saturated the product, %0d overran capacity",
                 sb.saturated_sets, sb.dropped_sets);
        if (sb.errors == 0)
            $display("sample_set_statistics_tb: clean");
        else
            $display("sample_set_statistics_tb: errors");
        $finish;
    end

endmodule
